// File: rtl/i2c_rts_pkg.sv
// i2c_rts_pkg: word types, event codes and error codes shared by the
// i2c register transaction sequencer modules. No dependencies.
package i2c_rts_pkg;

	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_ACK   = 3'd1;
	localparam logic [2:0] OP_NACK  = 3'd2;
	localparam logic [2:0] OP_RXB   = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_START = 2'd1;
	localparam logic [1:0] ERR_NACK  = 2'd2;
	localparam logic [1:0] ERR_UNEXP = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [6:0]  dev_addr;
		logic [7:0]  reg_index;
		logic [2:0]  byte_count;
		logic        is_read;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} cmd_word_t;

	typedef struct packed {
		logic        issue_start;
		logic        issue_stop;
		logic        issue_ack;
		logic        issue_nack;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        busy_res;
		logic        done_res;
		logic [31:0] read_word;
		logic [1:0]  error_code;
	} res_word_t;

endpackage

// File: rtl/i2c_rts_seq.sv
// i2c_rts_seq: transaction phase state and per-event result logic.
// Depends on i2c_rts_pkg.
module i2c_rts_seq #(
	parameter int MAX_BYTES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  i2c_rts_pkg::cmd_word_t cmd,
	output i2c_rts_pkg::res_word_t res
);
	import i2c_rts_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_REG   = 3'd2,
		PH_RADDR = 3'd3,
		PH_READ  = 3'd4,
		PH_WRITE = 3'd5,
		PH_STOP  = 3'd6
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [6:0]  taddr_q, taddr_d;
	logic [7:0]  treg_q, treg_d;
	logic [2:0]  left_q, left_d;
	logic [2:0]  sent_q, sent_d;
	logic        rmode_q, rmode_d;
	logic [31:0] sbuf_q, sbuf_d;
	logic [31:0] rword_q, rword_d;

	logic        st, sp, ak, nk, tv, done, abort;
	logic [7:0]  tb;
	logic [1:0]  err;
	logic [2:0]  cnt_c;
	logic [2:0]  k;

	function automatic logic [7:0] send_byte(input logic [31:0] data, input logic [2:0] idx);
		if (idx[2])
			return 8'd0;
		return data[{idx[1:0], 3'b000} +: 8];
	endfunction

	assign cnt_c = ({1'b0, cmd.byte_count} > 4'(MAX_BYTES)) ? 3'(MAX_BYTES) : cmd.byte_count;
	assign k = left_q - 3'd1;

	always_comb begin
		phase_d = phase_q;
		taddr_d = taddr_q;
		treg_d  = treg_q;
		left_d  = left_q;
		sent_d  = sent_q;
		rmode_d = rmode_q;
		sbuf_d  = sbuf_q;
		rword_d = rword_q;
		st = 1'b0;
		sp = 1'b0;
		ak = 1'b0;
		nk = 1'b0;
		tv = 1'b0;
		tb = 8'd0;
		done = 1'b0;
		abort = 1'b0;
		err = ERR_NONE;
		case (cmd.op)
			OP_START: begin
				if (phase_q != PH_IDLE || cmd.byte_count == 3'd0) begin
					err = ERR_START;
				end else begin
					taddr_d = cmd.dev_addr;
					treg_d  = cmd.reg_index;
					left_d  = cnt_c;
					sent_d  = 3'd0;
					rmode_d = cmd.is_read;
					sbuf_d  = cmd.write_data;
					rword_d = 32'd0;
					phase_d = PH_ADDR;
					st = 1'b1;
					tv = 1'b1;
					tb = {cmd.dev_addr, 1'b0};
				end
			end
			OP_ACK: begin
				unique case (phase_q)
					PH_ADDR: begin
						phase_d = PH_REG;
						tv = 1'b1;
						tb = treg_q;
					end
					PH_REG: begin
						if (rmode_q) begin
							phase_d = PH_RADDR;
							st = 1'b1;
							tv = 1'b1;
							tb = {taddr_q, 1'b1};
						end else begin
							phase_d = PH_WRITE;
							tv = 1'b1;
							tb = send_byte(sbuf_q, 3'd0);
							sent_d = 3'd1;
						end
					end
					PH_RADDR: phase_d = PH_READ;
					PH_WRITE: begin
						if (sent_q >= left_q) begin
							phase_d = PH_STOP;
							sp = 1'b1;
						end else begin
							tv = 1'b1;
							tb = send_byte(sbuf_q, sent_q);
							sent_d = sent_q + 3'd1;
						end
					end
					default: begin
						err = ERR_UNEXP;
						abort = 1'b1;
					end
				endcase
			end
			OP_NACK: begin
				err = ERR_NACK;
				abort = 1'b1;
			end
			OP_RXB: begin
				if (phase_q == PH_READ && left_q != 3'd0) begin
					if (!k[2])
						rword_d[{k[1:0], 3'b000} +: 8] =
							rword_q[{k[1:0], 3'b000} +: 8] | cmd.rx_byte;
					left_d = k;
					sent_d = sent_q + 3'd1;
					if (k != 3'd0) begin
						ak = 1'b1;
					end else begin
						nk = 1'b1;
						sp = 1'b1;
						phase_d = PH_STOP;
					end
				end else begin
					err = ERR_UNEXP;
					abort = 1'b1;
				end
			end
			OP_STOP: begin
				if (phase_q == PH_STOP) begin
					phase_d = PH_IDLE;
					done = 1'b1;
				end else begin
					err = ERR_UNEXP;
					abort = 1'b1;
				end
			end
			default: begin
				err = ERR_UNEXP;
				abort = 1'b1;
			end
		endcase
		if (abort)
			phase_d = PH_IDLE;

		res.issue_start = st;
		res.issue_stop  = sp;
		res.issue_ack   = ak;
		res.issue_nack  = nk;
		res.tx_valid    = tv;
		res.tx_byte     = tb;
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = done;
		res.read_word   = rword_d;
		res.error_code  = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			taddr_q <= 7'd0;
			treg_q  <= 8'd0;
			left_q  <= 3'd0;
			sent_q  <= 3'd0;
			rmode_q <= 1'b0;
			sbuf_q  <= 32'd0;
			rword_q <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			taddr_q <= taddr_d;
			treg_q  <= treg_d;
			left_q  <= left_d;
			sent_q  <= sent_d;
			rmode_q <= rmode_d;
			sbuf_q  <= sbuf_d;
			rword_q <= rword_d;
		end
	end

	a_abort_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (res.error_code == ERR_NACK || res.error_code == ERR_UNEXP)
		|=> phase_q == PH_IDLE)
		else $error("abort did not return to idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.done_res |=> phase_q == PH_IDLE && $past(phase_q) == PH_STOP)
		else $error("done outside stop phase");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.issue_start |=> phase_q == PH_ADDR || phase_q == PH_RADDR)
		else $error("start issued without address phase");

endmodule

// File: rtl/i2c_rts_obuf.sv
// i2c_rts_obuf: result output register with one skid stage.
// Depends on i2c_rts_pkg.
module i2c_rts_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2c_rts_pkg::res_word_t din,
	output logic                  can_push,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2c_rts_pkg::res_word_t res
);
	import i2c_rts_pkg::*;

	res_word_t out_q, skid_q;
	logic      out_v_q, skid_v_q;
	logic      pop;

	assign pop = out_v_q && res_ready;
	assign can_push = !skid_v_q;
	assign res_valid = out_v_q;
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (!out_v_q)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (push)
				out_q <= din;
		end else if (push) begin
			if (!out_v_q)
				out_q <= din;
			else
				skid_q <= din;
		end
	end

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while output is empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !pop |=> skid_v_q && $stable(skid_q))
		else $error("skid word lost");

	a_skid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && pop |=> out_v_q && !skid_v_q && out_q == $past(skid_q))
		else $error("skid word not forwarded");

endmodule

// File: rtl/i2c_register_transaction_sequencer.sv
// i2c_register_transaction_sequencer: top level, sequencer plus output buffer.
// Depends on i2c_rts_pkg, i2c_rts_seq, i2c_rts_obuf.
// Each accepted event word gives a result word, registered in the output buffer before it appears on res.
// Throughput: one event word per cycle while cmd_ready is high (the skid slot is empty);
// a two-word output stage lets cmd_ready stay high while one result waits.
// Reset: arst_n clears the phase to idle, the sequencer counters and registers to zero, and the buffer valid flags.
module i2c_register_transaction_sequencer #(
	parameter int MAX_BYTES = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  i2c_rts_pkg::cmd_word_t cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2c_rts_pkg::res_word_t res
);
	import i2c_rts_pkg::*;

	logic      accept;
	res_word_t step_res;

	assign accept = cmd_valid && cmd_ready;

	i2c_rts_seq #(
		.MAX_BYTES(MAX_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.res    (step_res)
	);

	i2c_rts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (step_res),
		.can_push  (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
